FILE: rtl/core/vsr_pkg.sv
// Shared constants, types and helpers of the voxel shape rasterizer.
package vsr_pkg;

    // Grid geometry
    localparam int MAX_DIM  = 32;
    localparam int NUM_AXES = 3;
    localparam int COORD_W  = $clog2(MAX_DIM);
    localparam int ADDR_W   = NUM_AXES * COORD_W;
    localparam int DEPTH    = 1 << ADDR_W;
    localparam int SIZE_W   = 6;
    localparam int EXT_W    = ($clog2(MAX_DIM + 1) > SIZE_W) ? $clog2(MAX_DIM + 1) : SIZE_W;

    // Word fields
    localparam int FUNC_W     = 3;
    localparam int POS_W      = 7;
    localparam int RAD_W      = 6;
    localparam int COLOR_W    = 8;
    localparam int NUM_CH     = 4;
    localparam int RGBA_W     = NUM_CH * COLOR_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Arithmetic widths
    localparam int SQ_W   = 2 * RAD_W;
    localparam int W_W    = 4 * RAD_W;
    localparam int Q_W    = 2 * POS_W - 1;
    localparam int MUL_W  = W_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int CMP_W  = POS_W + COORD_W;
    localparam int ACC_W  = 2 * $clog2(MAX_DIM + (1 << (POS_W - 1))) + W_W + 3;

    // Command codes
    localparam logic [FUNC_W-1:0] FN_SET_BOX = 3'd0;
    localparam logic [FUNC_W-1:0] FN_CLR_BOX = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SET_SPH = 3'd2;
    localparam logic [FUNC_W-1:0] FN_CLR_SPH = 3'd3;
    localparam logic [FUNC_W-1:0] FN_SET_ELL = 3'd4;
    localparam logic [FUNC_W-1:0] FN_CLR_ELL = 3'd5;
    localparam logic [FUNC_W-1:0] FN_READ    = 3'd6;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RED    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 3'd6;

    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 6'd32;
    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd128;

    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic signed [POS_W-1:0]  t_pos;
    typedef logic [COORD_W-1:0]       t_coord;
    typedef logic [EXT_W-1:0]         t_ext;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic signed [MUL_W-1:0]  t_mop;
    typedef logic signed [PROD_W-1:0] t_prod;

    // Everything the scanner needs to know about one axis
    typedef struct packed {
        t_pos             lo;
        t_pos             hi;
        t_ext             ext;
        t_acc             t0;
        t_acc             d0;
        logic [W_W-1:0]   w;
    } t_axis;

    typedef struct packed {
        logic start;
        logic box;
        logic strict;
    } t_scan_ctl;

    typedef struct packed {
        logic  we;
        t_addr addr;
    } t_wr;

    // Extent in use: a size above the grid acts as the full grid
    function automatic t_ext ext_of(input logic [SIZE_W-1:0] s);
        if (int'(s) > MAX_DIM) begin
            return t_ext'(MAX_DIM);
        end
        return t_ext'(s);
    endfunction

endpackage

FILE: rtl/core/voxel_shape_rasterizer.sv
// Top level of the voxel shape rasterizer: registers, sequencer, store and result word.
//
// Usage:
//  - Command channel (i_valid/o_ready): one word per command (func, corners or
//    center, radii). Result channel (o_valid/i_ready): one word per command.
//  - Config channel (i_cfg_valid/o_cfg_ready, always ready): index and data of a
//    register; write only while no command is in flight.
//  - After reset a clearing pass writes every one of the 2^(3*COORD_W) store
//    entries (32768 for a 32 grid) with o_ready low; config is taken.
//  - Box: straight to the scan, one voxel a cycle through the scanner.
//  - Sphere and ellipsoid: setup on the shared multiplier (16 products),
//    then the same scan.
//  - Read: one registered store read. Other bad and empty commands skip to the result.
//  - One command at a time: o_ready is high only when the sequencer is idle.
//  - The result word sits in an output register; the next command is taken
//    while it waits. If a result is ready while the receiver stalls, the
//    sequencer holds it until the output register frees up.
module voxel_shape_rasterizer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [vsr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [vsr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [vsr_pkg::FUNC_W-1:0]       i_func,
    input  logic signed [vsr_pkg::POS_W-1:0] i_x_a,
    input  logic signed [vsr_pkg::POS_W-1:0] i_x_b,
    input  logic signed [vsr_pkg::POS_W-1:0] i_y_a,
    input  logic signed [vsr_pkg::POS_W-1:0] i_y_b,
    input  logic signed [vsr_pkg::POS_W-1:0] i_z_a,
    input  logic signed [vsr_pkg::POS_W-1:0] i_z_b,
    input  logic [vsr_pkg::RAD_W-1:0]        i_radius_x,
    input  logic [vsr_pkg::RAD_W-1:0]        i_radius_y,
    input  logic [vsr_pkg::RAD_W-1:0]        i_radius_z,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_voxel_on,
    output logic [vsr_pkg::COLOR_W-1:0]      o_voxel_red,
    output logic [vsr_pkg::COLOR_W-1:0]      o_voxel_green,
    output logic [vsr_pkg::COLOR_W-1:0]      o_voxel_blue,
    output logic [vsr_pkg::COLOR_W-1:0]      o_voxel_alpha,
    output logic                             o_bad_command
);
    import vsr_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SETUP = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // Setup products, in order of dependence
    localparam logic [3:0] SU_AX = 4'd0;
    localparam logic [3:0] SU_AY = 4'd1;
    localparam logic [3:0] SU_AZ = 4'd2;
    localparam logic [3:0] SU_WX = 4'd3;
    localparam logic [3:0] SU_WY = 4'd4;
    localparam logic [3:0] SU_WZ = 4'd5;
    localparam logic [3:0] SU_P  = 4'd6;
    localparam logic [3:0] SU_QX = 4'd7;
    localparam logic [3:0] SU_TX = 4'd8;
    localparam logic [3:0] SU_DX = 4'd9;
    localparam logic [3:0] SU_QY = 4'd10;
    localparam logic [3:0] SU_TY = 4'd11;
    localparam logic [3:0] SU_DY = 4'd12;
    localparam logic [3:0] SU_QZ = 4'd13;
    localparam logic [3:0] SU_TZ = 4'd14;
    localparam logic [3:0] SU_DZ = 4'd15;

    logic [2:0]             r_state, n_state;
    t_addr                  r_clr;
    logic [3:0]             r_step;
    logic                   r_phase;
    logic                   r_scan_go;
    logic                   r_ovalid;

    logic [SIZE_W-1:0]      r_size  [NUM_AXES];
    logic [COLOR_W-1:0]     r_color [NUM_CH];

    t_pos                   r_lo  [NUM_AXES];
    t_pos                   r_hi  [NUM_AXES];
    logic [RAD_W-1:0]       r_rad [NUM_AXES];
    logic                   r_set, r_box, r_strict, r_sphere, r_is_read, r_bad;

    logic [SQ_W-1:0]        r_sq [NUM_AXES];
    logic [W_W-1:0]         r_w  [NUM_AXES];
    t_acc                   r_p;
    logic [Q_W-1:0]         r_q;
    t_acc                   r_t0 [NUM_AXES];
    t_acc                   r_d0 [NUM_AXES];

    logic                   r_o_on, r_o_bad;
    logic [RGBA_W-1:0]      r_o_rgba;

    t_ext                   ext   [NUM_AXES];
    logic signed [POS_W:0]  c_neg [NUM_AXES];
    logic signed [POS_W+1:0] c_df [NUM_AXES];
    logic                   acc, zero_ext, rad_zero, read_out, is_ell;
    logic                   clearing, out_load;
    t_mop                   mop_a, mop_b;
    t_prod                  prod;
    t_axis                  axis [NUM_AXES];
    t_scan_ctl              scan_ctl;
    t_wr                    wr;
    logic                   scan_done;

    logic                   on_we, col_we, on_wdata, rd_on;
    t_addr                  waddr, raddr;
    logic [RGBA_W-1:0]      col_wdata, rd_col;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == ST_IDLE);
    assign acc         = i_valid && o_ready;
    assign clearing    = (r_state == ST_CLEAR);
    assign out_load    = (r_state == ST_DONE) && (!r_ovalid || i_ready);

    // Extents, command checks and shape offsets
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            ext[a]   = ext_of(r_size[a]);
            c_neg[a] = -((POS_W + 1)'(r_lo[a]));
            c_df[a]  = ((POS_W + 2)'(c_neg[a]) <<< 1) + (POS_W + 2)'(1);
        end
        zero_ext = (ext[0] == '0) || (ext[1] == '0) || (ext[2] == '0);
        rad_zero = (i_radius_x == '0) || (i_radius_y == '0) || (i_radius_z == '0);
        read_out = (i_x_a < 0) || (i_y_a < 0) || (i_z_a < 0) ||
                   (CMP_W'(i_x_a) >= $signed(CMP_W'(ext[0]))) ||
                   (CMP_W'(i_y_a) >= $signed(CMP_W'(ext[1]))) ||
                   (CMP_W'(i_z_a) >= $signed(CMP_W'(ext[2])));
        is_ell   = (i_func == FN_SET_ELL) || (i_func == FN_CLR_ELL);
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == '1) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (acc) begin
                    priority if (i_func == FN_SET_BOX || i_func == FN_CLR_BOX) begin
                        n_state = zero_ext ? ST_DONE : ST_SCAN;
                    end else if (i_func == FN_SET_SPH || i_func == FN_CLR_SPH) begin
                        n_state = zero_ext ? ST_DONE : ST_SETUP;
                    end else if (is_ell) begin
                        n_state = (zero_ext || rad_zero) ? ST_DONE : ST_SETUP;
                    end else if (i_func == FN_READ) begin
                        n_state = ST_READ;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SETUP: begin
                if (r_phase && r_step == SU_DZ) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (scan_done) n_state = ST_DONE;
            end
            ST_READ: n_state = ST_DONE;
            ST_DONE: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_step    <= SU_AX;
            r_phase   <= 1'b0;
            r_scan_go <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_scan_go <= (n_state == ST_SCAN) && (r_state != ST_SCAN);
            if (clearing) begin
                r_clr <= r_clr + t_addr'(1);
            end
            if (acc) begin
                r_step  <= SU_AX;
                r_phase <= 1'b0;
            end else if (r_state == ST_SETUP) begin
                r_phase <= ~r_phase;
                if (r_phase) r_step <= r_step + 4'd1;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) r_size[a] <= SIZE_RESET;
            for (int c = 0; c < NUM_CH; c++) r_color[c] <= COLOR_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SIZE_X: r_size[0]  <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Y: r_size[1]  <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Z: r_size[2]  <= i_cfg_data[SIZE_W-1:0];
                CFG_RED:    r_color[0] <= i_cfg_data[COLOR_W-1:0];
                CFG_GREEN:  r_color[1] <= i_cfg_data[COLOR_W-1:0];
                CFG_BLUE:   r_color[2] <= i_cfg_data[COLOR_W-1:0];
                CFG_ALPHA:  r_color[3] <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // Command word capture
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_lo[0]   <= i_x_a;
            r_lo[1]   <= i_y_a;
            r_lo[2]   <= i_z_a;
            r_hi[0]   <= i_x_b;
            r_hi[1]   <= i_y_b;
            r_hi[2]   <= i_z_b;
            r_rad[0]  <= i_radius_x;
            r_rad[1]  <= i_radius_y;
            r_rad[2]  <= i_radius_z;
            r_set     <= (i_func == FN_SET_BOX) || (i_func == FN_SET_SPH) ||
                         (i_func == FN_SET_ELL);
            r_box     <= (i_func == FN_SET_BOX) || (i_func == FN_CLR_BOX);
            r_sphere  <= (i_func == FN_SET_SPH) || (i_func == FN_CLR_SPH);
            r_strict  <= (i_func == FN_SET_ELL);
            r_is_read <= (i_func == FN_READ);
            r_bad     <= (is_ell && rad_zero) || ((i_func == FN_READ) && read_out);
        end
    end

    // Setup operands for the shared multiplier; a sphere uses unit weights
    always_comb begin
        mop_a = t_mop'(1);
        mop_b = t_mop'(1);
        unique case (r_step)
            SU_AX: begin mop_a = t_mop'(r_rad[0]); mop_b = t_mop'(r_rad[0]); end
            SU_AY: begin mop_a = t_mop'(r_rad[1]); mop_b = t_mop'(r_rad[1]); end
            SU_AZ: begin mop_a = t_mop'(r_rad[2]); mop_b = t_mop'(r_rad[2]); end
            SU_WX: begin
                if (!r_sphere) begin mop_a = t_mop'(r_sq[1]); mop_b = t_mop'(r_sq[2]); end
            end
            SU_WY: begin
                if (!r_sphere) begin mop_a = t_mop'(r_sq[0]); mop_b = t_mop'(r_sq[2]); end
            end
            SU_WZ: begin
                if (!r_sphere) begin mop_a = t_mop'(r_sq[0]); mop_b = t_mop'(r_sq[1]); end
            end
            SU_P: begin
                if (r_sphere) begin
                    mop_a = t_mop'(r_sq[0]);
                end else begin
                    mop_a = t_mop'(r_w[2]);
                    mop_b = t_mop'(r_sq[2]);
                end
            end
            SU_QX: begin mop_a = t_mop'(c_neg[0]); mop_b = t_mop'(c_neg[0]); end
            SU_TX: begin mop_a = t_mop'(r_q);      mop_b = t_mop'(r_w[0]);   end
            SU_DX: begin mop_a = t_mop'(c_df[0]);  mop_b = t_mop'(r_w[0]);   end
            SU_QY: begin mop_a = t_mop'(c_neg[1]); mop_b = t_mop'(c_neg[1]); end
            SU_TY: begin mop_a = t_mop'(r_q);      mop_b = t_mop'(r_w[1]);   end
            SU_DY: begin mop_a = t_mop'(c_df[1]);  mop_b = t_mop'(r_w[1]);   end
            SU_QZ: begin mop_a = t_mop'(c_neg[2]); mop_b = t_mop'(c_neg[2]); end
            SU_TZ: begin mop_a = t_mop'(r_q);      mop_b = t_mop'(r_w[2]);   end
            SU_DZ: begin mop_a = t_mop'(c_df[2]);  mop_b = t_mop'(r_w[2]);   end
        endcase
    end

    vsr_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mop_a),
        .i_b   (mop_b),
        .o_p   (prod)
    );

    // Product write-back in the second phase of each step
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SETUP && r_phase) begin
            unique case (r_step)
                SU_AX: r_sq[0] <= prod[SQ_W-1:0];
                SU_AY: r_sq[1] <= prod[SQ_W-1:0];
                SU_AZ: r_sq[2] <= prod[SQ_W-1:0];
                SU_WX: r_w[0]  <= prod[W_W-1:0];
                SU_WY: r_w[1]  <= prod[W_W-1:0];
                SU_WZ: r_w[2]  <= prod[W_W-1:0];
                SU_P:  r_p     <= prod[ACC_W-1:0];
                SU_QX: r_q     <= prod[Q_W-1:0];
                SU_TX: r_t0[0] <= prod[ACC_W-1:0];
                SU_DX: r_d0[0] <= prod[ACC_W-1:0];
                SU_QY: r_q     <= prod[Q_W-1:0];
                SU_TY: r_t0[1] <= prod[ACC_W-1:0];
                SU_DY: r_d0[1] <= prod[ACC_W-1:0];
                SU_QZ: r_q     <= prod[Q_W-1:0];
                SU_TZ: r_t0[2] <= prod[ACC_W-1:0];
                SU_DZ: r_d0[2] <= prod[ACC_W-1:0];
            endcase
        end
    end

    // Scanner hookup
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            axis[a].lo  = r_lo[a];
            axis[a].hi  = r_hi[a];
            axis[a].ext = ext[a];
            axis[a].t0  = r_t0[a];
            axis[a].d0  = r_d0[a];
            axis[a].w   = r_w[a];
        end
        scan_ctl.start  = r_scan_go;
        scan_ctl.box    = r_box;
        scan_ctl.strict = r_strict;
    end

    vsr_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_axis  (axis),
        .i_p     (r_p),
        .o_wr    (wr),
        .o_done  (scan_done)
    );

    // Store ports: clearing pass, else scanner writes; a clear keeps the color
    always_comb begin
        waddr     = clearing ? r_clr : wr.addr;
        on_we     = clearing || wr.we;
        on_wdata  = !clearing && r_set;
        col_we    = clearing || (wr.we && r_set);
        col_wdata = clearing ? '0 : {r_color[0], r_color[1], r_color[2], r_color[3]};
        raddr     = {r_lo[2][COORD_W-1:0], r_lo[1][COORD_W-1:0], r_lo[0][COORD_W-1:0]};
    end

    vsr_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_on_ram (
        .i_clk   (i_clk),
        .i_we    (on_we),
        .i_waddr (waddr),
        .i_wdata (on_wdata),
        .i_raddr (raddr),
        .o_rdata (rd_on)
    );

    vsr_ram #(.WIDTH(RGBA_W), .DEPTH(DEPTH)) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (waddr),
        .i_wdata (col_wdata),
        .i_raddr (raddr),
        .o_rdata (rd_col)
    );

    // Result word register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_on   <= r_is_read && !r_bad && rd_on;
            r_o_rgba <= (r_is_read && !r_bad) ? rd_col : '0;
            r_o_bad  <= r_bad;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_voxel_on    = r_o_on;
    assign o_voxel_red   = r_o_rgba[4*COLOR_W-1:3*COLOR_W];
    assign o_voxel_green = r_o_rgba[3*COLOR_W-1:2*COLOR_W];
    assign o_voxel_blue  = r_o_rgba[2*COLOR_W-1:COLOR_W];
    assign o_voxel_alpha = r_o_rgba[COLOR_W-1:0];
    assign o_bad_command = r_o_bad;
endmodule

FILE: rtl/core/vsr_ram.sv
// Generic simple dual-port RAM with registered read.
module vsr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

FILE: rtl/core/vsr_mul.sv
// Shared signed multiplier with registered product, used by the setup sequencer.
module vsr_mul (
    input  logic          i_clk,
    input  vsr_pkg::t_mop i_a,
    input  vsr_pkg::t_mop i_b,
    output vsr_pkg::t_prod o_p
);
    import vsr_pkg::*;

    always_ff @(posedge i_clk) begin
        o_p <= t_prod'(i_a) * t_prod'(i_b);
    end
endmodule

FILE: rtl/core/vsr_scan.sv
// Grid scanner: walks x, y, z one voxel a cycle, keeps the quadric terms by
// forward differences and decides which voxels a command touches.
module vsr_scan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vsr_pkg::t_scan_ctl i_ctl,
    input  vsr_pkg::t_axis     i_axis [vsr_pkg::NUM_AXES],
    input  vsr_pkg::t_acc      i_p,
    output vsr_pkg::t_wr       o_wr,
    output logic               o_done
);
    import vsr_pkg::*;

    t_coord                r_cnt [NUM_AXES];
    t_acc                  r_t   [NUM_AXES];
    t_acc                  r_d   [NUM_AXES];
    logic                  r_act;
    logic [NUM_AXES:0]     step;
    logic [NUM_AXES-1:0]   wrap;
    logic [NUM_AXES-1:0]   inb;
    logic                  last;

    logic  r_v1, r_last1, r_inb1;
    t_addr r_addr1;
    t_acc  r_s1;
    logic  r_v2, r_last2, r_hit2;
    t_addr r_addr2;

    // Odometer carries and box membership per axis
    always_comb begin
        step[0] = 1'b1;
        for (int a = 0; a < NUM_AXES; a++) begin
            wrap[a]     = (t_ext'(r_cnt[a]) == (i_axis[a].ext - t_ext'(1)));
            step[a + 1] = step[a] & wrap[a];
            inb[a]      = ($signed(CMP_W'(r_cnt[a])) >= CMP_W'(i_axis[a].lo)) &&
                          ($signed(CMP_W'(r_cnt[a])) <= CMP_W'(i_axis[a].hi));
        end
        last = step[NUM_AXES];
    end

    // Scan active flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else if (i_ctl.start) begin
            r_act <= 1'b1;
        end else if (r_act && last) begin
            r_act <= 1'b0;
        end
    end

    // Counters and forward-difference terms: (d+1)^2 w = d^2 w + (2d+1) w
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < NUM_AXES; a++) begin
            if (i_ctl.start) begin
                r_cnt[a] <= '0;
                r_t[a]   <= i_axis[a].t0;
                r_d[a]   <= i_axis[a].d0;
            end else if (r_act && step[a]) begin
                if (wrap[a]) begin
                    r_cnt[a] <= '0;
                    r_t[a]   <= i_axis[a].t0;
                    r_d[a]   <= i_axis[a].d0;
                end else begin
                    r_cnt[a] <= r_cnt[a] + t_coord'(1);
                    r_t[a]   <= r_t[a] + r_d[a];
                    r_d[a]   <= r_d[a] + t_acc'({i_axis[a].w, 1'b0});
                end
            end
        end
    end

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= r_act;
            r_v2 <= r_v1;
        end
    end

    // Stage 1: sum of terms; stage 2: inside test
    always_ff @(posedge i_clk) begin
        r_last1 <= last;
        r_inb1  <= &inb;
        r_addr1 <= {r_cnt[2], r_cnt[1], r_cnt[0]};
        r_s1    <= r_t[0] + r_t[1] + r_t[2];
        r_last2 <= r_last1;
        r_addr2 <= r_addr1;
        if (i_ctl.box) begin
            r_hit2 <= r_inb1;
        end else if (i_ctl.strict) begin
            r_hit2 <= (r_s1 < i_p);
        end else begin
            r_hit2 <= (r_s1 <= i_p);
        end
    end

    assign o_wr.we   = r_v2 && r_hit2;
    assign o_wr.addr = r_addr2;
    assign o_done    = r_v2 && r_last2;
endmodule

FILE: rtl/core/vsr_checker.sv
// Port-level checks of the voxel shape rasterizer and their bind.
module vsr_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [vsr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input logic [vsr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input logic                             i_valid,
    input logic                             o_ready,
    input logic [vsr_pkg::FUNC_W-1:0]       i_func,
    input logic signed [vsr_pkg::POS_W-1:0] i_x_a,
    input logic signed [vsr_pkg::POS_W-1:0] i_x_b,
    input logic signed [vsr_pkg::POS_W-1:0] i_y_a,
    input logic signed [vsr_pkg::POS_W-1:0] i_y_b,
    input logic signed [vsr_pkg::POS_W-1:0] i_z_a,
    input logic signed [vsr_pkg::POS_W-1:0] i_z_b,
    input logic [vsr_pkg::RAD_W-1:0]        i_radius_x,
    input logic [vsr_pkg::RAD_W-1:0]        i_radius_y,
    input logic [vsr_pkg::RAD_W-1:0]        i_radius_z,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic                             o_voxel_on,
    input logic [vsr_pkg::COLOR_W-1:0]      o_voxel_red,
    input logic [vsr_pkg::COLOR_W-1:0]      o_voxel_green,
    input logic [vsr_pkg::COLOR_W-1:0]      o_voxel_blue,
    input logic [vsr_pkg::COLOR_W-1:0]      o_voxel_alpha,
    input logic                             o_bad_command
);
    import vsr_pkg::*;

    // A stalled result word stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable({o_voxel_on, o_voxel_red, o_voxel_green,
                                         o_voxel_blue, o_voxel_alpha, o_bad_command}))
        else $error("result word changed while stalled");

    // One command at a time: busy right after a command is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second command taken back to back");

    // A rejected command reports no voxel
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_command |-> !o_voxel_on && o_voxel_red == '0 &&
            o_voxel_green == '0 && o_voxel_blue == '0 && o_voxel_alpha == '0)
        else $error("bad command carries voxel data");
endmodule

bind voxel_shape_rasterizer vsr_checker u_vsr_checker (.*);
